FILE: sv/dct8_pkg.sv
// ============================================================================
// dct8_pkg
// Shared constants, coefficient math and control types for the 8-point DCT.
// ============================================================================
package dct8_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 21;

    // Default fraction bits of the fixed-point rotation constants
    localparam int COEF_FRAC_BITS = 14;

    // Decimal scale of the constant table below
    localparam logic [63:0] DEC9  = 64'd1000000000;
    localparam logic [63:0] DEC18 = 64'd1000000000000000000;

    // Constant values times 10^18
    localparam logic [63:0] V_C1   = 64'd980785280403230449;
    localparam logic [63:0] V_S1   = 64'd195090322016128268;
    localparam logic [63:0] V_C3   = 64'd831469612302545237;
    localparam logic [63:0] V_S3   = 64'd555570233019602225;
    localparam logic [63:0] V_R2C6 = 64'd541196100146196984;
    localparam logic [63:0] V_R2S6 = 64'd1306562964876376528;
    localparam logic [63:0] V_R2   = 64'd1414213562373095049;

    // Stage enables handed to a rotator: product stage, then sum/round stage
    typedef struct packed {
        logic en_mul;
        logic en_sum;
    } t_rot_ctl;

    // round(x / 10^18 * 2^frac), exact in 64-bit integer math.
    // Elaboration use only.
    function automatic logic [63:0] qconst(input logic [63:0] x, input int unsigned frac);
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] a;
        logic [63:0] t;
        hi = x / DEC9;
        lo = x % DEC9;
        a  = hi << frac;
        t  = (a % DEC9) * DEC9 + (lo << frac) + DEC18 / 2;
        return a / DEC9 + t / DEC18;
    endfunction

endpackage

FILE: sv/dct8_fixed_point_core.sv
// ============================================================================
// dct8_fixed_point_core
// Eight-point forward DCT, Loeffler flow, fixed point, one row per cycle unless stalled.
// ============================================================================
// Takes one word of eight signed 16-bit samples per clock, unless stalled,
// and returns one word of eight 21-bit coefficients in natural frequency
// order, unnormalized (coef_0 is the plain sum). Throughput is one word per
// cycle while the output is not stalled. There are six register stages;
// the first is loaded at the accepting edge. The stages: input butterflies,
// first rotators' products, their rounding, second rotator's round plus odd
// butterflies, final butterfly with sqrt2 products, and the final rounding
// into the output register. Each stage advances on its own, so bubbles are
// squeezed out and a new word is taken while a finished one waits at the
// output. Rotation constants are rounded to COEF_FRAC_BITS fraction bits;
// every product sum rounds half up.
module dct8_fixed_point_core #(
    parameter int COEF_FRAC_BITS = dct8_pkg::COEF_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [dct8_pkg::SAMPLE_W-1:0] i_sample_0,
    input  logic signed [dct8_pkg::SAMPLE_W-1:0] i_sample_1,
    input  logic signed [dct8_pkg::SAMPLE_W-1:0] i_sample_2,
    input  logic signed [dct8_pkg::SAMPLE_W-1:0] i_sample_3,
    input  logic signed [dct8_pkg::SAMPLE_W-1:0] i_sample_4,
    input  logic signed [dct8_pkg::SAMPLE_W-1:0] i_sample_5,
    input  logic signed [dct8_pkg::SAMPLE_W-1:0] i_sample_6,
    input  logic signed [dct8_pkg::SAMPLE_W-1:0] i_sample_7,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [dct8_pkg::COEF_W-1:0]   o_coef_0,
    output logic signed [dct8_pkg::COEF_W-1:0]   o_coef_1,
    output logic signed [dct8_pkg::COEF_W-1:0]   o_coef_2,
    output logic signed [dct8_pkg::COEF_W-1:0]   o_coef_3,
    output logic signed [dct8_pkg::COEF_W-1:0]   o_coef_4,
    output logic signed [dct8_pkg::COEF_W-1:0]   o_coef_5,
    output logic signed [dct8_pkg::COEF_W-1:0]   o_coef_6,
    output logic signed [dct8_pkg::COEF_W-1:0]   o_coef_7
);

    localparam int NSTG = 6;
    localparam int CW   = COEF_FRAC_BITS + 2;
    localparam int PW5  = 20 + CW;
    localparam int SW5  = PW5 + 1;
    localparam logic signed [SW5-1:0] Half5 = SW5'(1) << (COEF_FRAC_BITS - 1);

    // Rotation constants
    localparam logic signed [CW-1:0] K_C1 =
        CW'(dct8_pkg::qconst(dct8_pkg::V_C1, COEF_FRAC_BITS));
    localparam logic signed [CW-1:0] K_S1 =
        CW'(dct8_pkg::qconst(dct8_pkg::V_S1, COEF_FRAC_BITS));
    localparam logic signed [CW-1:0] K_C3 =
        CW'(dct8_pkg::qconst(dct8_pkg::V_C3, COEF_FRAC_BITS));
    localparam logic signed [CW-1:0] K_S3 =
        CW'(dct8_pkg::qconst(dct8_pkg::V_S3, COEF_FRAC_BITS));
    localparam logic signed [CW-1:0] K_R2C6 =
        CW'(dct8_pkg::qconst(dct8_pkg::V_R2C6, COEF_FRAC_BITS));
    localparam logic signed [CW-1:0] K_R2S6 =
        CW'(dct8_pkg::qconst(dct8_pkg::V_R2S6, COEF_FRAC_BITS));
    localparam logic signed [CW-1:0] K_R2 =
        CW'(dct8_pkg::qconst(dct8_pkg::V_R2, COEF_FRAC_BITS));

    typedef logic signed [16:0] t_s17;
    typedef logic signed [17:0] t_s18;
    typedef logic signed [18:0] t_s19;
    typedef logic signed [19:0] t_s20;
    typedef logic signed [20:0] t_s21;

    // Pipeline control
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] en;

    // Stage registers
    t_s17 r_a [8];
    t_s18 r_e [4];
    t_s19 r_b0_2, r_b1_2;
    t_s19 r_b0_3, r_b1_3;
    t_s20 r_d4, r_d5, r_d6, r_d7;
    t_s19 r_b0_4, r_b1_4, r_c2_4, r_c3_4;
    t_s21 r_f4, r_f7;
    logic signed [PW5-1:0] r_p5, r_p6;
    t_s21 r_coef [8];

    // Rotator outputs
    t_s19 rot4, rot7, rot5, rot6, rot2, rot3;
    logic signed [SW5-1:0] sum5, sum6;

    dct8_pkg::t_rot_ctl ctl_odd;
    dct8_pkg::t_rot_ctl ctl_even;

    // A stage moves when it is empty or the next one moves
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld[0] = en[0] ? i_valid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[NSTG-1];

    // Stage 0: input butterflies
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_a[0] <= t_s17'(i_sample_0) + t_s17'(i_sample_7);
            r_a[7] <= t_s17'(i_sample_0) - t_s17'(i_sample_7);
            r_a[1] <= t_s17'(i_sample_1) + t_s17'(i_sample_6);
            r_a[6] <= t_s17'(i_sample_1) - t_s17'(i_sample_6);
            r_a[2] <= t_s17'(i_sample_2) + t_s17'(i_sample_5);
            r_a[5] <= t_s17'(i_sample_2) - t_s17'(i_sample_5);
            r_a[3] <= t_s17'(i_sample_3) + t_s17'(i_sample_4);
            r_a[4] <= t_s17'(i_sample_3) - t_s17'(i_sample_4);
        end
    end

    // Stage 1: even butterflies; odd rotator products (in dct8_rot)
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_e[0] <= t_s18'(r_a[0]) + t_s18'(r_a[3]);
            r_e[3] <= t_s18'(r_a[0]) - t_s18'(r_a[3]);
            r_e[1] <= t_s18'(r_a[1]) + t_s18'(r_a[2]);
            r_e[2] <= t_s18'(r_a[1]) - t_s18'(r_a[2]);
        end
    end

    assign ctl_odd.en_mul  = en[1];
    assign ctl_odd.en_sum  = en[2];
    assign ctl_even.en_mul = en[2];
    assign ctl_even.en_sum = en[3];

    // Odd rotators: 3pi/16 on (4,7), pi/16 on (5,6)
    dct8_rot #(.DW(17), .OW(19), .FRAC(COEF_FRAC_BITS)) u_rot_47 (
        .i_clk (i_clk),
        .i_ctl (ctl_odd),
        .i_x   (r_a[4]),
        .i_y   (r_a[7]),
        .i_c   (K_C3),
        .i_s   (K_S3),
        .o_a   (rot4),
        .o_b   (rot7)
    );

    dct8_rot #(.DW(17), .OW(19), .FRAC(COEF_FRAC_BITS)) u_rot_56 (
        .i_clk (i_clk),
        .i_ctl (ctl_odd),
        .i_x   (r_a[5]),
        .i_y   (r_a[6]),
        .i_c   (K_C1),
        .i_s   (K_S1),
        .o_a   (rot5),
        .o_b   (rot6)
    );

    // Even rotator: sqrt2 times 6pi/16 on (2,3)
    dct8_rot #(.DW(18), .OW(19), .FRAC(COEF_FRAC_BITS)) u_rot_23 (
        .i_clk (i_clk),
        .i_ctl (ctl_even),
        .i_x   (r_e[2]),
        .i_y   (r_e[3]),
        .i_c   (K_R2C6),
        .i_s   (K_R2S6),
        .o_a   (rot2),
        .o_b   (rot3)
    );

    // Stage 2: DC / Nyquist butterfly
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_b0_2 <= t_s19'(r_e[0]) + t_s19'(r_e[1]);
            r_b1_2 <= t_s19'(r_e[0]) - t_s19'(r_e[1]);
        end
    end

    // Stage 3: odd butterflies on rotated terms
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_b0_3 <= r_b0_2;
            r_b1_3 <= r_b1_2;
            r_d4   <= t_s20'(rot4) + t_s20'(rot6);
            r_d6   <= t_s20'(rot4) - t_s20'(rot6);
            r_d7   <= t_s20'(rot7) + t_s20'(rot5);
            r_d5   <= t_s20'(rot7) - t_s20'(rot5);
        end
    end

    // Stage 4: last butterfly and sqrt2 products
    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_b0_4 <= r_b0_3;
            r_b1_4 <= r_b1_3;
            r_c2_4 <= rot2;
            r_c3_4 <= rot3;
            r_f7   <= t_s21'(r_d7) + t_s21'(r_d4);
            r_f4   <= t_s21'(r_d7) - t_s21'(r_d4);
            r_p5   <= PW5'(r_d5) * PW5'(K_R2);
            r_p6   <= PW5'(r_d6) * PW5'(K_R2);
        end
    end

    // Stage 5: round sqrt2 terms, reorder into the output word
    assign sum5 = SW5'(r_p5) + Half5;
    assign sum6 = SW5'(r_p6) + Half5;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_coef[0] <= t_s21'(r_b0_4);
            r_coef[1] <= r_f7;
            r_coef[2] <= t_s21'(r_c2_4);
            r_coef[3] <= t_s21'(sum5 >>> COEF_FRAC_BITS);
            r_coef[4] <= t_s21'(r_b1_4);
            r_coef[5] <= t_s21'(sum6 >>> COEF_FRAC_BITS);
            r_coef[6] <= t_s21'(r_c3_4);
            r_coef[7] <= r_f4;
        end
    end

    assign o_coef_0 = r_coef[0];
    assign o_coef_1 = r_coef[1];
    assign o_coef_2 = r_coef[2];
    assign o_coef_3 = r_coef[3];
    assign o_coef_4 = r_coef[4];
    assign o_coef_5 = r_coef[5];
    assign o_coef_6 = r_coef[6];
    assign o_coef_7 = r_coef[7];

`ifndef SYNTHESIS
    // an accepted word lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_vld[0])
        else $error("accepted word missing from first stage");

    // input is held off only when every stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled with a free stage");

    // a stalled output word stays valid and holds its value at the output
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_coef_0) && $stable(o_coef_7))
        else $error("output word lost under stall");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");
`endif

endmodule

FILE: sv/dct8_rot.sv
// ============================================================================
// dct8_rot
// Two-stage plane rotator: a = x*c + y*s, b = y*c - x*s, each rounded
// half-up and shifted right by FRAC bits.
// ============================================================================
module dct8_rot #(
    parameter int DW   = 17,
    parameter int OW   = 19,
    parameter int FRAC = dct8_pkg::COEF_FRAC_BITS
) (
    input  logic                       i_clk,
    input  dct8_pkg::t_rot_ctl         i_ctl,
    input  logic signed [DW-1:0]       i_x,
    input  logic signed [DW-1:0]       i_y,
    input  logic signed [FRAC+1:0]     i_c,
    input  logic signed [FRAC+1:0]     i_s,
    output logic signed [OW-1:0]       o_a,
    output logic signed [OW-1:0]       o_b
);

    localparam int CW = FRAC + 2;
    localparam int PW = DW + CW;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] Half = SW'(1) << (FRAC - 1);

    logic signed [PW-1:0] r_xc;
    logic signed [PW-1:0] r_ys;
    logic signed [PW-1:0] r_yc;
    logic signed [PW-1:0] r_xs;
    logic signed [SW-1:0] sum_a;
    logic signed [SW-1:0] sum_b;
    logic signed [OW-1:0] r_a;
    logic signed [OW-1:0] r_b;

    // product stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            r_xc <= PW'(i_x) * PW'(i_c);
            r_ys <= PW'(i_y) * PW'(i_s);
            r_yc <= PW'(i_y) * PW'(i_c);
            r_xs <= PW'(i_x) * PW'(i_s);
        end
    end

    // sum, round half up, drop fraction
    assign sum_a = SW'(r_xc) + SW'(r_ys) + Half;
    assign sum_b = SW'(r_yc) - SW'(r_xs) + Half;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_sum) begin
            r_a <= OW'(sum_a >>> FRAC);
            r_b <= OW'(sum_b >>> FRAC);
        end
    end

    assign o_a = r_a;
    assign o_b = r_b;

endmodule
